/* sv/itf_pkg.sv */
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, character codes and constants of the integer to text
// formatter: radix codes, operand size codes and controller handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  localparam int OUTPUT_LIMIT_DEF = 64;

  localparam int VALUE_W          = 64;
  localparam int BCD_DIGITS       = 20;
  localparam int DIGIT_LIMIT_OFF  = 64;

  // floor(x / 3) as (x * 43) >> 7, exact for x below 128
  localparam int OCT_RECIP        = 43;
  localparam int OCT_SHIFT        = 7;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_O       = 8'h6f;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;
  localparam logic [1:0] SIZE_64 = 2'd3;

  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_HEX = 2'd1,
    MODE_OCT = 2'd2,
    MODE_BIN = 2'd3
  } itf_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_LIMIT,
    ST_LAYOUT,
    ST_EMIT
  } itf_state_t;

  typedef struct packed {
    logic capture;
    logic conv_step;
    logic count;
    logic limit;
    logic layout;
    logic emit;
  } itf_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic empty;
    logic emit_done;
  } itf_status_t;

endpackage

`default_nettype wire

/* sv/itf_ctrl.sv */
// ----------------------------------------------------------------------------
// itf_ctrl
// Sequencer of the formatter: capture, serial conversion, three setup steps
// and character emission.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  itf_pkg::itf_status_t status,
  output itf_pkg::itf_cmd_t    cmd
);
  import itf_pkg::*;

  itf_state_t state;
  itf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_done) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.count  = 1'b1;
        state_next = ST_LIMIT;
      end
      ST_LIMIT: begin
        cmd.limit  = 1'b1;
        state_next = ST_LAYOUT;
      end
      ST_LAYOUT: begin
        cmd.layout = 1'b1;
        // nothing to print: no transfer at all
        state_next = status.empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

/* sv/itf_datapath.sv */
// ----------------------------------------------------------------------------
// itf_datapath
// Magnitude and sign capture, bit-serial binary to BCD conversion, digit
// count and field layout, and the registered character output.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_datapath #(
  parameter int OUTPUT_LIMIT = itf_pkg::OUTPUT_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  itf_pkg::itf_cmd_t    cmd,
  output itf_pkg::itf_status_t status,
  input  logic [63:0]          value,
  input  logic [1:0]           value_size,
  input  logic                 is_signed,
  input  logic [1:0]           mode,
  input  logic                 uppercase,
  input  logic                 left_justify,
  input  logic                 force_sign,
  input  logic                 space_sign,
  input  logic                 radix_prefix,
  input  logic                 zero_pad,
  input  logic [5:0]           min_width,
  input  logic [6:0]           digit_limit,
  output logic [7:0]           out_char,
  output logic                 last,
  output logic                 truncated,
  output logic                 char_valid
);
  import itf_pkg::*;

  localparam logic [6:0] LimitW = 7'(OUTPUT_LIMIT);

  // request fields
  itf_mode_t    mode_q;
  logic         upper_q;
  logic         left_q;
  logic         zpad_q;
  logic [5:0]   width_q;
  logic [6:0]   limit_q;
  logic         sign_on;
  logic [7:0]   sign_char;
  logic         pfx_on;
  logic [7:0]   pfx_char;

  // conversion
  logic [VALUE_W-1:0]      mag;
  logic [4*BCD_DIGITS-1:0] bcd;
  logic [4*BCD_DIGITS-1:0] bcd_adj;
  logic [5:0]              step;
  logic [6:0]              bitlen;

  // counts and layout
  logic [6:0] nd_raw;
  logic       is_zero;
  logic [6:0] nd;
  logic [6:0] zf;
  logic [6:0] b0, b1, b2, b3, b4;
  logic [6:0] emit_last;
  logic       trunc_q;
  logic [6:0] k;
  logic [5:0] didx;

  // capture logic
  logic [VALUE_W-1:0] vmask;
  logic               vsign;
  logic [VALUE_W-1:0] masked;
  logic [VALUE_W-1:0] negated;
  logic               neg;

  always_comb begin
    case (value_size)
      SIZE_8: begin
        vmask = 64'h0000_0000_0000_00ff;
        vsign = value[7];
      end
      SIZE_16: begin
        vmask = 64'h0000_0000_0000_ffff;
        vsign = value[15];
      end
      SIZE_32: begin
        vmask = 64'h0000_0000_ffff_ffff;
        vsign = value[31];
      end
      default: begin
        vmask = 64'hffff_ffff_ffff_ffff;
        vsign = value[63];
      end
    endcase
  end

  assign masked  = value & vmask;
  assign negated = (~masked + 64'd1) & vmask;
  assign neg     = is_signed & vsign;

  // add-3 correction of every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // digit counts per radix
  logic [6:0]  dec_nd;
  logic [6:0]  hex_sum;
  logic [12:0] oct_prod;
  logic [6:0]  nd_raw_c;

  always_comb begin
    dec_nd = 7'd1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        dec_nd = 7'(i + 1);
      end
    end
  end

  assign hex_sum  = bitlen + 7'd3;
  assign oct_prod = ({6'd0, bitlen} + 13'd2) * 13'(OCT_RECIP);

  always_comb begin
    case (mode_q)
      MODE_DEC: nd_raw_c = dec_nd;
      MODE_HEX: nd_raw_c = {2'b00, hex_sum[6:2]};
      MODE_OCT: nd_raw_c = 7'(oct_prod >> OCT_SHIFT);
      MODE_BIN: nd_raw_c = bitlen;
      default:  nd_raw_c = bitlen;
    endcase
  end

  // digit limit and zero fill
  logic [6:0] nd_c;
  logic [6:0] zf_c;

  always_comb begin
    if (is_zero) begin
      nd_c = 7'd1;
    end else if (limit_q < 7'(DIGIT_LIMIT_OFF) && limit_q < nd_raw) begin
      nd_c = limit_q;
    end else begin
      nd_c = nd_raw;
    end
    zf_c = (zpad_q && ({1'b0, width_q} > nd_c)) ? {1'b0, width_q} - nd_c : 7'd0;
  end

  // field boundaries
  logic [6:0] n_c;
  logic [6:0] pad_c;
  logic [6:0] total_c;
  logic [6:0] pre_c;
  logic [6:0] b1_c, b2_c, b3_c, b4_c;
  logic [6:0] emit_c;

  always_comb begin
    n_c     = {6'd0, sign_on} + (pfx_on ? 7'd2 : 7'd0) + zf + nd;
    pad_c   = ({1'b0, width_q} > n_c) ? {1'b0, width_q} - n_c : 7'd0;
    total_c = n_c + pad_c;
    pre_c   = left_q ? 7'd0 : pad_c;
    b1_c    = pre_c + {6'd0, sign_on};
    b2_c    = b1_c + (pfx_on ? 7'd2 : 7'd0);
    b3_c    = b2_c + zf;
    b4_c    = b3_c + nd;
    emit_c  = (total_c > LimitW) ? LimitW : total_c;
  end

  // digit select and character
  logic [4*BCD_DIGITS-1:0] dec_sh;
  logic [VALUE_W-1:0]      hex_sh;
  logic [VALUE_W+1:0]      oct_sh;
  logic [VALUE_W-1:0]      bin_sh;
  logic [3:0]              digit;
  logic [7:0]              digit_char;
  logic [7:0]              pad_char;
  logic                    in_digits;
  logic [7:0]              char_c;

  assign dec_sh = bcd >> {didx, 2'b00};
  assign hex_sh = mag >> {didx, 2'b00};
  assign oct_sh = {2'b00, mag} >> (8'(didx) * 8'd3);
  assign bin_sh = mag >> didx;

  always_comb begin
    case (mode_q)
      MODE_DEC: digit = dec_sh[3:0];
      MODE_HEX: digit = hex_sh[3:0];
      MODE_OCT: digit = {1'b0, oct_sh[2:0]};
      MODE_BIN: digit = {3'b000, bin_sh[0]};
      default:  digit = dec_sh[3:0];
    endcase
    if (digit < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, digit};
    end else begin
      digit_char = (upper_q ? CH_UPPER_A : CH_LOWER_A) + {4'd0, digit} - 8'd10;
    end
  end

  assign pad_char  = zpad_q ? CH_ZERO : CH_SPACE;
  assign in_digits = (k >= b3) && (k < b4);

  always_comb begin
    if (k < b0) begin
      char_c = pad_char;
    end else if (k < b1) begin
      char_c = sign_char;
    end else if (k < b2) begin
      char_c = (k == b1) ? CH_ZERO : pfx_char;
    end else if (k < b3) begin
      char_c = CH_ZERO;
    end else if (k < b4) begin
      char_c = digit_char;
    end else begin
      char_c = pad_char;
    end
  end

  assign status.conv_done = (step == 6'd63);
  assign status.empty     = (total_c == 7'd0);
  assign status.emit_done = (k == emit_last);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q    <= itf_mode_t'(mode);
      upper_q   <= uppercase;
      left_q    <= left_justify;
      zpad_q    <= zero_pad;
      width_q   <= min_width;
      limit_q   <= digit_limit;
      sign_on   <= neg | force_sign | space_sign;
      sign_char <= neg ? CH_MINUS : (force_sign ? CH_PLUS : CH_SPACE);
      pfx_on    <= radix_prefix && (itf_mode_t'(mode) != MODE_DEC);
      case (itf_mode_t'(mode))
        MODE_HEX: pfx_char <= CH_X;
        MODE_OCT: pfx_char <= CH_O;
        default:  pfx_char <= CH_B;
      endcase
      mag    <= neg ? negated : masked;
      bcd    <= '0;
      step   <= '0;
      bitlen <= '0;
    end
    if (cmd.conv_step) begin
      // rotate so the magnitude is back in place after the last step
      mag  <= {mag[VALUE_W-2:0], mag[VALUE_W-1]};
      bcd  <= {bcd_adj[4*BCD_DIGITS-2:0], mag[VALUE_W-1]};
      step <= step + 6'd1;
      if (bitlen == 7'd0 && mag[VALUE_W-1]) begin
        bitlen <= 7'd64 - {1'b0, step};
      end
    end
    if (cmd.count) begin
      nd_raw  <= nd_raw_c;
      is_zero <= (bitlen == 7'd0);
    end
    if (cmd.limit) begin
      nd <= nd_c;
      zf <= zf_c;
    end
    if (cmd.layout) begin
      b0        <= pre_c;
      b1        <= b1_c;
      b2        <= b2_c;
      b3        <= b3_c;
      b4        <= b4_c;
      emit_last <= emit_c - 7'd1;
      trunc_q   <= (total_c > LimitW);
      k         <= '0;
      didx      <= 6'(nd - 7'd1);
    end
    if (cmd.emit) begin
      k <= k + 7'd1;
      if (in_digits) begin
        didx <= didx - 6'd1;
      end
      out_char  <= char_c;
      last      <= status.emit_done;
      truncated <= status.emit_done & trunc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_valid <= cmd.emit;
    end
  end

endmodule

`default_nettype wire

/* sv/integer_to_text_formatter_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_text_formatter_unit
// Formats one integer request as ASCII text, one character per strobe.
//
//   channel   handshake               payload
//   request   start / busy            value .. digit_limit
//   result    char_valid (strobe)     out_char, last, truncated
//
// A request is taken when start is high and busy is low. The magnitude goes
// through a bit-serial BCD conversion, then the setup steps of digit count,
// digit limit and field layout, then one character per cycle, with 0 to
// OUTPUT_LIMIT characters in all; the last strobe is out in the first cycle
// with busy low. Synchronous reset clears the sequencer and the strobe. The
// receiver cannot stall: each character is on the ports for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_text_formatter_unit #(
  parameter int OUTPUT_LIMIT = itf_pkg::OUTPUT_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic [1:0]  value_size,
  input  logic        is_signed,
  input  logic [1:0]  mode,
  input  logic        uppercase,
  input  logic        left_justify,
  input  logic        force_sign,
  input  logic        space_sign,
  input  logic        radix_prefix,
  input  logic        zero_pad,
  input  logic [5:0]  min_width,
  input  logic [6:0]  digit_limit,
  output logic        char_valid,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        truncated
);
  import itf_pkg::*;

  itf_cmd_t    cmd;
  itf_status_t status;

  itf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  itf_datapath #(
    .OUTPUT_LIMIT (OUTPUT_LIMIT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .value_size   (value_size),
    .is_signed    (is_signed),
    .mode         (mode),
    .uppercase    (uppercase),
    .left_justify (left_justify),
    .force_sign   (force_sign),
    .space_sign   (space_sign),
    .radix_prefix (radix_prefix),
    .zero_pad     (zero_pad),
    .min_width    (min_width),
    .digit_limit  (digit_limit),
    .out_char     (out_char),
    .last         (last),
    .truncated    (truncated),
    .char_valid   (char_valid)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the integer to text formatter. A table of directed requests
// (extremes, every radix, sign and padding options, empty output,
// truncation) is followed by random requests. Each request is sent with
// start/busy and a random gap. Every character strobe is checked against
// the text that the table gives or a local formatter predicts for each accepted transfer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import itf_pkg::*;

  localparam int         TEXT_LIMIT   = OUTPUT_LIMIT_DEF;
  localparam logic [6:0] NO_LIMIT     = 7'(DIGIT_LIMIT_OFF);
  localparam int         RANDOM_ITEMS = 200;
  localparam int         DRAIN_CYCLES = 160;
  localparam int         CYCLE_LIMIT  = 200000;

  // option flags of a directed row
  localparam logic [5:0] F_NONE   = 6'b000000;
  localparam logic [5:0] F_UPPER  = 6'b100000;
  localparam logic [5:0] F_LEFT   = 6'b010000;
  localparam logic [5:0] F_PLUS   = 6'b001000;
  localparam logic [5:0] F_SPACE  = 6'b000100;
  localparam logic [5:0] F_PREFIX = 6'b000010;
  localparam logic [5:0] F_ZPAD   = 6'b000001;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  size;
    logic        is_signed;
    itf_mode_t   mode;
    logic        uppercase;
    logic        left_justify;
    logic        force_sign;
    logic        space_sign;
    logic        radix_prefix;
    logic        zero_pad;
    logic [5:0]  min_width;
    logic [6:0]  digit_limit;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       truncated;
  } text_char_t;

  typedef struct {
    fmt_req_t req;
    bit       typed;
    string    txt;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  fmt_req_t req_drv;
  logic char_valid;
  logic [7:0] out_char;
  logic last;
  logic truncated;

  text_char_t pending_chars[$];
  directed_row_t rows[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  integer_to_text_formatter_unit #(
    .OUTPUT_LIMIT(TEXT_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(req_drv.value),
    .value_size(req_drv.size),
    .is_signed(req_drv.is_signed),
    .mode(req_drv.mode),
    .uppercase(req_drv.uppercase),
    .left_justify(req_drv.left_justify),
    .force_sign(req_drv.force_sign),
    .space_sign(req_drv.space_sign),
    .radix_prefix(req_drv.radix_prefix),
    .zero_pad(req_drv.zero_pad),
    .min_width(req_drv.min_width),
    .digit_limit(req_drv.digit_limit),
    .char_valid(char_valid),
    .out_char(out_char),
    .last(last),
    .truncated(truncated)
  );

  always #4 clk = ~clk;

  function automatic string append_char(string s, logic [7:0] c);
    return $sformatf("%s%c", s, c);
  endfunction

  // full text of one request, before the output limit is applied
  function automatic string format_text(fmt_req_t r);
    int unsigned bits;
    logic [63:0] mask;
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] d;
    logic [7:0] digit_buf[64];
    logic [7:0] pad_char;
    logic negative;
    int nd;
    int lim;
    int pad;
    string body;
    string text;
    bits = 8 << r.size;
    mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
    mag = r.value & mask;
    negative = 1'b0;
    if (r.is_signed && mag[bits-1]) begin
      negative = 1'b1;
      mag = (~mag + 64'd1) & mask;
    end
    case (r.mode)
      MODE_DEC: radix = 64'd10;
      MODE_HEX: radix = 64'd16;
      MODE_OCT: radix = 64'd8;
      default:  radix = 64'd2;
    endcase
    lim = (r.digit_limit >= NO_LIMIT) ? 64 : int'(r.digit_limit);
    nd = 0;
    if (mag == 64'd0) begin
      digit_buf[0] = CH_ZERO;
      nd = 1;
    end else begin
      // only the lowest digits survive the limit
      while (mag != 64'd0 && nd < lim) begin
        d = mag % radix;
        if (d < 64'd10)
          digit_buf[nd] = CH_ZERO + d[7:0];
        else
          digit_buf[nd] = (r.uppercase ? CH_UPPER_A : CH_LOWER_A) + d[7:0] - 8'd10;
        mag = mag / radix;
        nd++;
      end
    end
    body = "";
    if (negative)
      body = append_char(body, CH_MINUS);
    else if (r.force_sign)
      body = append_char(body, CH_PLUS);
    else if (r.space_sign)
      body = append_char(body, CH_SPACE);
    if (r.radix_prefix && r.mode != MODE_DEC) begin
      body = append_char(body, CH_ZERO);
      case (r.mode)
        MODE_HEX: body = append_char(body, CH_X);
        MODE_OCT: body = append_char(body, CH_O);
        default:  body = append_char(body, CH_B);
      endcase
    end
    // zero fill counts the digits only
    if (r.zero_pad)
      for (int i = nd; i < int'(r.min_width); i++)
        body = append_char(body, CH_ZERO);
    for (int i = nd - 1; i >= 0; i--)
      body = append_char(body, digit_buf[i]);
    pad = (int'(r.min_width) > body.len()) ? int'(r.min_width) - body.len() : 0;
    pad_char = r.zero_pad ? CH_ZERO : CH_SPACE;
    text = "";
    if (!r.left_justify)
      for (int i = 0; i < pad; i++)
        text = append_char(text, pad_char);
    text = {text, body};
    if (r.left_justify)
      for (int i = 0; i < pad; i++)
        text = append_char(text, pad_char);
    return text;
  endfunction

  function automatic void add_row(logic [63:0] value, logic [1:0] size, logic sgn,
                                  itf_mode_t mode, logic [5:0] flags,
                                  logic [5:0] width, logic [6:0] limit,
                                  bit typed, string txt);
    directed_row_t row;
    row.req.value        = value;
    row.req.size         = size;
    row.req.is_signed    = sgn;
    row.req.mode         = mode;
    row.req.uppercase    = (flags & F_UPPER) != 0;
    row.req.left_justify = (flags & F_LEFT) != 0;
    row.req.force_sign   = (flags & F_PLUS) != 0;
    row.req.space_sign   = (flags & F_SPACE) != 0;
    row.req.radix_prefix = (flags & F_PREFIX) != 0;
    row.req.zero_pad     = (flags & F_ZPAD) != 0;
    row.req.min_width    = width;
    row.req.digit_limit  = limit;
    row.typed            = typed;
    row.txt              = txt;
    rows.push_back(row);
  endfunction

  function automatic fmt_req_t rand_request();
    fmt_req_t r;
    int unsigned bits;
    r.size = 2'($urandom_range(0, 3));
    bits = 8 << r.size;
    case ($urandom_range(0, 3))
      0: r.value = {$urandom, $urandom};
      1: r.value = 64'($urandom_range(0, 300));
      2: r.value = $urandom_range(0, 1) ? '1 : (64'd1 << (bits - 1));
      default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    r.is_signed    = 1'($urandom_range(0, 1));
    r.mode         = itf_mode_t'($urandom_range(0, 3));
    r.uppercase    = 1'($urandom_range(0, 1));
    r.left_justify = 1'($urandom_range(0, 1));
    r.force_sign   = 1'($urandom_range(0, 1));
    r.space_sign   = 1'($urandom_range(0, 1));
    r.radix_prefix = 1'($urandom_range(0, 1));
    r.zero_pad     = 1'($urandom_range(0, 1));
    r.min_width    = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 12));
    r.digit_limit  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, NO_LIMIT))
                                                 : NO_LIMIT;
    return r;
  endfunction

  // entered right after a falling edge; returns right after one
  task automatic send_request(fmt_req_t r, string txt);
    int gap;
    int n;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_drv <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // transfer taken at this edge
    n = (txt.len() > TEXT_LIMIT) ? TEXT_LIMIT : txt.len();
    for (int k = 0; k < n; k++)
      pending_chars.push_back('{txt[k], k == n - 1,
                                (k == n - 1) && (txt.len() > TEXT_LIMIT)});
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst && char_valid) begin
      got = '{out_char, last, truncated};
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char %h last %b truncated %b",
                 $time, out_char, last, truncated);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (got !== want) begin
          $display("%0t: expected char %h last %b truncated %b, got char %h last %b truncated %b",
                   $time, want.ch, want.last, want.truncated, got.ch, got.last,
                   got.truncated);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req_drv = '0;

    //      value                   size     sgn  mode      flags                       wid lim
    add_row(64'd0,                  SIZE_8,  0, MODE_DEC, F_NONE,                      0, NO_LIMIT, TYPED, "0");
    add_row(64'd0,                  SIZE_8,  0, MODE_DEC, F_NONE,                      0, 0,        TYPED, "0");
    add_row(64'd255,                SIZE_8,  0, MODE_DEC, F_NONE,                      0, NO_LIMIT, TYPED, "255");
    add_row(64'd255,                SIZE_8,  1, MODE_DEC, F_NONE,                      0, NO_LIMIT, TYPED, "-1");
    add_row(64'h80,                 SIZE_8,  1, MODE_DEC, F_NONE,                      0, NO_LIMIT, TYPED, "-128");
    add_row(64'h8000_0000_0000_0000, SIZE_64, 1, MODE_DEC, F_NONE,                     0, NO_LIMIT, TYPED,
            "-9223372036854775808");
    add_row('1,                     SIZE_64, 0, MODE_DEC, F_NONE,                      0, NO_LIMIT, TYPED,
            "18446744073709551615");
    add_row(64'hdead_beef,          SIZE_32, 0, MODE_HEX, F_PREFIX,                    0, NO_LIMIT, TYPED, "0xdeadbeef");
    add_row(64'hdead_beef,          SIZE_32, 0, MODE_HEX, F_PREFIX | F_UPPER,          0, NO_LIMIT, TYPED, "0xDEADBEEF");
    add_row(64'd8,                  SIZE_16, 0, MODE_OCT, F_PREFIX,                    0, NO_LIMIT, TYPED, "0o10");
    add_row(64'd5,                  SIZE_16, 0, MODE_BIN, F_PREFIX,                    0, NO_LIMIT, TYPED, "0b101");
    add_row(64'd42,                 SIZE_32, 0, MODE_DEC, F_PREFIX,                    0, NO_LIMIT, TYPED, "42");
    add_row(64'd42,                 SIZE_32, 1, MODE_DEC, F_PLUS,                      0, NO_LIMIT, TYPED, "+42");
    add_row(64'd42,                 SIZE_32, 1, MODE_DEC, F_SPACE,                     0, NO_LIMIT, TYPED, " 42");
    add_row(64'd42,                 SIZE_32, 1, MODE_DEC, F_PLUS | F_SPACE,            0, NO_LIMIT, TYPED, "+42");
    add_row(64'd42,                 SIZE_32, 0, MODE_DEC, F_NONE,                      6, NO_LIMIT, TYPED, "    42");
    add_row(64'd42,                 SIZE_32, 0, MODE_DEC, F_LEFT,                      6, NO_LIMIT, TYPED, "42    ");
    add_row(64'd42,                 SIZE_32, 0, MODE_DEC, F_ZPAD,                      6, NO_LIMIT, TYPED, "000042");
    add_row(64'd42,                 SIZE_32, 0, MODE_DEC, F_ZPAD | F_PLUS,             6, NO_LIMIT, TYPED, "+000042");
    add_row(64'h1234,               SIZE_16, 1, MODE_HEX, F_ZPAD | F_LEFT | F_PREFIX,  9, NO_LIMIT, PREDICTED, "");
    add_row(64'd12345,              SIZE_32, 0, MODE_DEC, F_NONE,                      0, 0,        TYPED, "");
    add_row(64'd12345,              SIZE_32, 0, MODE_DEC, F_PLUS,                      0, 0,        TYPED, "+");
    add_row(64'd12345,              SIZE_32, 0, MODE_DEC, F_NONE,                      0, 2,        TYPED, "45");
    add_row(64'habc_def,            SIZE_32, 0, MODE_HEX, F_UPPER | F_LEFT | F_PREFIX, 20, NO_LIMIT, PREDICTED, "");
    // overlong text: sign, prefix and 64 binary digits
    add_row('1,                     SIZE_64, 0, MODE_BIN, F_PLUS | F_PREFIX,           63, NO_LIMIT, PREDICTED, "");
    // overlong text from zero fill at the widest width
    add_row(64'd1,                  SIZE_64, 0, MODE_HEX, F_ZPAD | F_PLUS | F_PREFIX,  63, NO_LIMIT, PREDICTED, "");

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i])
      send_request(rows[i].req, rows[i].typed ? rows[i].txt : format_text(rows[i].req));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      fmt_req_t r;
      r = rand_request();
      send_request(r, format_text(r));
    end
    start <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
